### design/hs_pkg.sv
// Shared constants, types and sequencer states for the heap sorter.
`default_nettype none

package hs_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int NODE_W = $clog2(2 * DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int CMP_W  = 11;

  localparam logic [CMP_W-1:0] CMP_MAX = {CMP_W{1'b1}};

  typedef logic signed [DATA_W-1:0] word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BUILD,
    S_LOAD,
    S_EXTRACT,
    S_SWAP,
    S_SIFT_RD,
    S_SIFT_CMP,
    S_EMIT_RD,
    S_EMIT
  } state_t;

  typedef enum logic {
    PH_BUILD,
    PH_EXTRACT
  } phase_t;

  typedef struct packed {
    logic             vld;
    word_t            value;
    logic             last;
    logic [CMP_W-1:0] count;
  } emit_t;

endpackage

`default_nettype wire

### design/hs_if.sv
// Valid/ready channel interfaces for the heap sorter input and result streams.
`default_nettype none

interface hs_in_if;
  import hs_pkg::*;

  logic  valid;
  logic  ready;
  word_t value;
  logic  is_last;

  modport source (output valid, output value, output is_last, input ready);
  modport sink (input valid, input value, input is_last, output ready);
endinterface

interface hs_out_if;
  import hs_pkg::*;

  logic             valid;
  logic             ready;
  word_t            sorted_value;
  logic             is_final;
  logic [CMP_W-1:0] comparison_count;

  modport source (output valid, output sorted_value, output is_final,
                  output comparison_count, input ready);
  modport sink (input valid, input sorted_value, input is_final,
                input comparison_count, output ready);
endinterface

`default_nettype wire

### design/hs_ram.sv
// Generic RAM with one write port and two registered read ports.
`default_nettype none

module hs_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

### design/hs_seq.sv
// Heap sequencer: loads the store, builds the heap, extracts and streams it out.
`default_nettype none

module hs_seq (
  input  logic          clk,
  input  logic          rst,
  hs_in_if.sink         feed,
  output hs_pkg::emit_t emit,
  input  logic          emit_take
);
  import hs_pkg::*;

  state_t state, state_next;
  phase_t phase;

  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] k;
  logic [CNT_W-1:0] size;
  logic [IDX_W-1:0] hole;
  logic [IDX_W-1:0] emit_idx;
  word_t            moving;
  logic [CMP_W-1:0] cmp_cnt;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  word_t             wdata;
  logic [IDX_W-1:0]  raddr_a;
  logic [IDX_W-1:0]  raddr_b;
  word_t             rd_a;
  word_t             rd_b;

  logic              fill_full;
  logic [CNT_W-1:0]  n_load;
  logic [CNT_W-1:0]  km1;
  logic [NODE_W-1:0] left;
  logic [NODE_W-1:0] right;
  logic              left_ok;
  logic              right_ok;
  logic              l_gt;
  word_t             top_val;
  logic              r_gt;
  logic              child_win;
  logic [IDX_W-1:0]  child_idx;
  word_t             child_val;
  logic [CMP_W:0]    cmp_sum;
  logic [CMP_W-1:0]  cmp_upd;
  logic              emit_last;
  state_t            ret_state;

  hs_ram #(
    .DEPTH (DEPTH),
    .WIDTH (DATA_W)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  assign fill_full = (fill == CNT_W'(DEPTH));
  assign n_load    = fill_full ? fill : fill + CNT_W'(1);
  assign km1       = k - CNT_W'(1);
  assign left      = (NODE_W'(hole) << 1) + NODE_W'(1);
  assign right     = (NODE_W'(hole) << 1) + NODE_W'(2);
  assign left_ok   = (left < NODE_W'(size));
  assign right_ok  = (right < NODE_W'(size));

  assign l_gt      = (rd_a > moving);
  assign top_val   = l_gt ? rd_a : moving;
  assign r_gt      = right_ok && (rd_b > top_val);
  assign child_win = l_gt || r_gt;
  assign child_idx = r_gt ? right[IDX_W-1:0] : left[IDX_W-1:0];
  assign child_val = r_gt ? rd_b : rd_a;

  assign cmp_sum   = {1'b0, cmp_cnt} + (right_ok ? (CMP_W+1)'(2) : (CMP_W+1)'(1));
  assign cmp_upd   = (cmp_sum > {1'b0, CMP_MAX}) ? CMP_MAX : cmp_sum[CMP_W-1:0];

  assign emit_last = ((CNT_W'(emit_idx) + CNT_W'(1)) == n);
  assign ret_state = (phase == PH_BUILD) ? S_BUILD : S_EXTRACT;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (feed.valid && feed.is_last) begin
          state_next = S_BUILD;
        end
      end
      S_BUILD: begin
        state_next = (k != '0) ? S_LOAD : S_EXTRACT;
      end
      S_LOAD: begin
        state_next = S_SIFT_RD;
      end
      S_EXTRACT: begin
        state_next = (k != '0) ? S_SWAP : S_EMIT_RD;
      end
      S_SWAP: begin
        state_next = S_SIFT_RD;
      end
      S_SIFT_RD: begin
        state_next = left_ok ? S_SIFT_CMP : ret_state;
      end
      S_SIFT_CMP: begin
        state_next = child_win ? S_SIFT_RD : ret_state;
      end
      S_EMIT_RD: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (emit_take) begin
          state_next = emit_last ? S_IDLE : S_EMIT_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    feed.ready = 1'b0;
    we         = 1'b0;
    waddr      = hole;
    wdata      = moving;
    raddr_a    = hole;
    raddr_b    = '0;
    emit       = '0;
    case (state)
      S_IDLE: begin
        feed.ready = 1'b1;
        we         = feed.valid && !fill_full;
        waddr      = fill[IDX_W-1:0];
        wdata      = feed.value;
      end
      S_BUILD: begin
        raddr_a = km1[IDX_W-1:0];
      end
      S_EXTRACT: begin
        raddr_a = '0;
        raddr_b = k[IDX_W-1:0];
      end
      S_SWAP: begin
        we    = 1'b1;
        waddr = k[IDX_W-1:0];
        wdata = rd_a;
      end
      S_SIFT_RD: begin
        if (left_ok) begin
          raddr_a = left[IDX_W-1:0];
          raddr_b = right[IDX_W-1:0];
        end else begin
          we = 1'b1;
        end
      end
      S_SIFT_CMP: begin
        we    = 1'b1;
        wdata = child_win ? child_val : moving;
      end
      S_EMIT_RD: begin
        raddr_a = emit_idx;
      end
      S_EMIT: begin
        raddr_a    = emit_idx;
        emit.vld   = 1'b1;
        emit.value = rd_a;
        emit.last  = emit_last;
        emit.count = cmp_cnt;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      cmp_cnt <= '0;
      phase   <= PH_BUILD;
    end else begin
      case (state)
        S_IDLE: begin
          if (feed.valid) begin
            if (!fill_full) begin
              fill <= fill + CNT_W'(1);
            end
            if (feed.is_last) begin
              n       <= n_load;
              k       <= n_load >> 1;
              cmp_cnt <= '0;
              phase   <= PH_BUILD;
            end
          end
        end
        S_BUILD: begin
          if (k != '0) begin
            hole <= km1[IDX_W-1:0];
            k    <= km1;
          end else begin
            k     <= n - CNT_W'(1);
            phase <= PH_EXTRACT;
          end
        end
        S_LOAD: begin
          moving <= rd_a;
          size   <= n;
        end
        S_EXTRACT: begin
          if (k == '0) begin
            emit_idx <= '0;
          end
        end
        S_SWAP: begin
          moving <= rd_b;
          hole   <= '0;
          size   <= k;
          k      <= km1;
        end
        S_SIFT_CMP: begin
          cmp_cnt <= cmp_upd;
          if (child_win) begin
            hole <= child_idx;
          end
        end
        S_EMIT: begin
          if (emit_take) begin
            if (emit_last) begin
              fill <= '0;
            end else begin
              emit_idx <= emit_idx + IDX_W'(1);
            end
          end
        end
        default: begin
          fill <= fill;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(DEPTH))
    else $error("fill count beyond store depth");

  a_stop_after_last: assert property (@(posedge clk) disable iff (rst)
    (feed.valid && feed.ready && feed.is_last) |=> !feed.ready)
    else $error("input still open after the closing transfer");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && $past(state) != S_IDLE) |-> (cmp_cnt >= $past(cmp_cnt)))
    else $error("comparison count fell during a sort");

  a_hole_in_heap: assert property (@(posedge clk) disable iff (rst)
    (state == S_SIFT_RD || state == S_SIFT_CMP) |-> (CNT_W'(hole) < size))
    else $error("sift position outside the heap");

  a_emit_in_batch: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (CNT_W'(emit_idx) < n))
    else $error("emit index outside the batch");
`endif

endmodule

`default_nettype wire

### design/heap_sorter.sv
// Heap sorter top level: sequencer with heap store, and the result output register.
// Loading: one element transfer per cycle while idle; no result for elements not flagged last.
// Sort of N elements: paced by the one compare unit and the two-read, one-write heap store;
//   each sift level takes a read and a compare state, each emitted result a read and an emit state.
// Results stream out in ascending order; input is closed meanwhile.
// Reset clears the sequencer, fill count, comparison count and output valid; store is not cleared.
`default_nettype none

module heap_sorter (
  input  logic     clk,
  input  logic     rst,
  hs_in_if.sink    feed,
  hs_out_if.source result
);
  import hs_pkg::*;

  emit_t            emit;
  logic             emit_take;
  logic             out_valid;
  word_t            out_value;
  logic             out_final;
  logic [CMP_W-1:0] out_count;

  hs_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .feed      (feed),
    .emit      (emit),
    .emit_take (emit_take)
  );

  assign emit_take = emit.vld && (!out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_take) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_take) begin
      out_value <= emit.value;
      out_final <= emit.last;
      out_count <= emit.count;
    end
  end

  assign result.valid            = out_valid;
  assign result.sorted_value     = out_value;
  assign result.is_final         = out_final;
  assign result.comparison_count = out_count;

endmodule

`default_nettype wire

### tb/tb.sv
// Testbench for heap_sorter: random and directed batches checked against an in-bench heapsort.
`timescale 1ns / 100ps

module tb;
  import hs_pkg::*;

  typedef struct {
    word_t value;
    logic  last;
  } feed_item_t;

  typedef struct {
    word_t            value;
    logic             is_final;
    logic [CMP_W-1:0] count;
  } sorted_t;

  logic clk;
  logic rst;

  hs_in_if  feed ();
  hs_out_if result ();

  heap_sorter i_dut (
    .clk    (clk),
    .rst    (rst),
    .feed   (feed),
    .result (result)
  );

  feed_item_t feed_q[$];
  sorted_t    sorted_q[$];

  word_t            heap_mem[DEPTH];
  int               heap_fill;
  logic [CMP_W-1:0] cmp_total;

  int send_idle_pct;
  int recv_stall_pct;
  int errors;

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    feed.valid = 1'b0;
    feed.value = '0;
    feed.is_last = 1'b0;
    result.ready = 1'b0;
  end

  always #5 clk = ~clk;

  function automatic void count_compare();
    if (cmp_total != CMP_MAX) cmp_total++;
  endfunction

  function automatic void heap_sift(int size, int root);
    int    top;
    int    left;
    int    right;
    bit    done;
    word_t tmp;
    done = 1'b0;
    while (!done) begin
      top = root;
      left = 2 * root + 1;
      right = 2 * root + 2;
      if (left < size) begin
        count_compare();
        if (heap_mem[left] > heap_mem[top]) top = left;
      end
      if (right < size) begin
        count_compare();
        if (heap_mem[right] > heap_mem[top]) top = right;
      end
      if (top == root) begin
        done = 1'b1;
      end else begin
        tmp = heap_mem[root];
        heap_mem[root] = heap_mem[top];
        heap_mem[top] = tmp;
        root = top;
      end
    end
  endfunction

  function automatic void heap_accept(word_t value, logic last);
    int      n;
    word_t   tmp;
    sorted_t res;
    if (heap_fill < DEPTH) begin
      heap_mem[heap_fill] = value;
      heap_fill++;
    end
    if (last) begin
      n = heap_fill;
      cmp_total = '0;
      for (int k = n / 2; k > 0; k--) heap_sift(n, k - 1);
      for (int k = n - 1; k > 0; k--) begin
        tmp = heap_mem[0];
        heap_mem[0] = heap_mem[k];
        heap_mem[k] = tmp;
        heap_sift(k, 0);
      end
      for (int k = 0; k < n; k++) begin
        res.value = heap_mem[k];
        res.is_final = (k == n - 1);
        res.count = cmp_total;
        sorted_q.push_back(res);
      end
      heap_fill = 0;
    end
  endfunction

  // driver
  always @(posedge clk) begin : drive
    feed_item_t nxt;
    if (rst) begin
      feed.valid <= 1'b0;
      heap_fill = 0;
      cmp_total = '0;
    end else begin
      if (feed.valid && feed.ready) heap_accept(feed.value, feed.is_last);
      if (!feed.valid || feed.ready) begin
        if (feed_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = feed_q.pop_front();
          feed.valid <= 1'b1;
          feed.value <= nxt.value;
          feed.is_last <= nxt.last;
        end else begin
          feed.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : watch
    sorted_t exp;
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        if (sorted_q.size() == 0) begin
          $display("%0t unexpected result: value %0d final %0b count %0d", $time,
                   result.sorted_value, result.is_final, result.comparison_count);
          errors++;
        end else begin
          exp = sorted_q.pop_front();
          if (result.sorted_value !== exp.value) begin
            $display("%0t sorted_value mismatch: expected %0d actual %0d", $time,
                     exp.value, result.sorted_value);
            errors++;
          end
          if (result.is_final !== exp.is_final) begin
            $display("%0t is_final mismatch: expected %0b actual %0b", $time,
                     exp.is_final, result.is_final);
            errors++;
          end
          if (result.comparison_count !== exp.count) begin
            $display("%0t comparison_count mismatch: expected %0d actual %0d", $time,
                     exp.count, result.comparison_count);
            errors++;
          end
        end
      end
      result.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic word_t pick_word(int mode);
    case (mode)
      0: return word_t'($urandom());
      1: return word_t'($signed($urandom_range(16)) - 8);
      2: begin
        case ($urandom_range(4))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return 32'sh0;
          3: return -32'sd1;
          default: return word_t'($urandom());
        endcase
      end
      default: return word_t'({$urandom_range(1) ? 16'hffff : 16'h0, 16'($urandom())});
    endcase
  endfunction

  task automatic add_item(word_t value, logic last);
    feed_item_t it;
    it.value = value;
    it.last = last;
    feed_q.push_back(it);
  endtask

  task automatic add_batch(int n);
    int mode;
    mode = $urandom_range(3);
    for (int i = 0; i < n; i++) add_item(pick_word(mode), i == n - 1);
  endtask

  initial begin : stimulus
    int budget;
    int n;
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase

      if (ph == 0) begin
        add_item(32'sd5, 1'b1);
        add_item(32'sh7fffffff, 1'b0);
        add_item(32'sh80000000, 1'b0);
        add_item(32'sh0, 1'b0);
        add_item(-32'sd1, 1'b0);
        add_item(32'sd1, 1'b0);
        add_item(32'sh80000001, 1'b1);
        add_item(32'sd3, 1'b0);
        add_item(32'sd3, 1'b0);
        add_item(-32'sd3, 1'b0);
        add_item(32'sd3, 1'b1);
        add_item(-32'sd9, 1'b0);
        add_item(32'sd9, 1'b1);
        for (int i = 0; i < 5; i++) add_item(word_t'(i * 100 - 200), i == 4);
        for (int i = 0; i < 5; i++) add_item(word_t'(200 - i * 100), i == 4);
      end

      budget = 20;
      while (budget > 0) begin
        n = ($urandom_range(3) == 0) ? 1 : $urandom_range(2, 12);
        if (n > budget) n = budget;
        add_batch(n);
        budget -= n;
      end

      if (ph == 1) add_batch(DEPTH);
      if (ph == 2) add_batch(DEPTH + $urandom_range(1, 4));

      while (feed_q.size() != 0) @(posedge clk);
    end

    while (feed.valid) @(posedge clk);
    while (sorted_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule

### heap_sorter.f
design/hs_pkg.sv
design/hs_if.sv
design/hs_ram.sv
design/hs_seq.sv
design/heap_sorter.sv
tb/tb.sv
